### rtl/core/wbrm_pkg.sv
// Shared types and constants for the windowed byte rate meter.
package wbrm_pkg;

  localparam int NOW_W   = 32;  // time in seconds, slot numbers
  localparam int BYTES_W = 24;  // byte count of one word
  localparam int TOTAL_W = 40;  // per-slot and window totals, rate
  localparam int GRAND_W = 63;  // running total
  localparam int DVD_W   = 38;  // divider dividend: window total / 4
  localparam int DVS_W   = 32;  // divider divisor: elapsed seconds

  // One reading, classified by the front end
  typedef struct packed {
    logic [NOW_W-1:0]   now_seconds;
    logic [NOW_W-1:0]   now_slot;
    logic [BYTES_W-1:0] byte_count;
    logic               restart;
  } wbrm_item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_FIX,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CUR,
    B_NEXT,
    B_ADD,
    B_DIFF,
    B_DIV,
    B_PUT
  } back_state_t;

endpackage

### rtl/core/wbrm_front.sv
// Front end: accepts a reading and turns its time into a slot number.
module wbrm_front import wbrm_pkg::*; #(
  parameter int SLOT_SECONDS = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [NOW_W-1:0]    in_now_seconds,
  input  logic [BYTES_W-1:0]  in_byte_count,
  input  logic                in_restart,
  output logic                q_push,
  output wbrm_item_t          q_item,
  input  logic                q_full
);

  localparam int SS_W = $clog2(SLOT_SECONDS + 1);
  localparam int QS_W = NOW_W + SS_W;
  // floor(2^32 / SLOT_SECONDS); the estimate below is low by at most one
  localparam logic [NOW_W:0] RECIP = (NOW_W+1)'((64'd1 << NOW_W) / SLOT_SECONDS);

  front_state_t         state_r, state_nxt;
  logic [NOW_W-1:0]     now_r;
  logic [BYTES_W-1:0]   bytes_r;
  logic                 restart_r;
  logic [63:0]          prod_r;
  logic [NOW_W-1:0]     q0_r;
  logic [QS_W-1:0]      qs_r;
  logic [QS_W-1:0]      rem;
  logic [NOW_W-1:0]     slot;

  // remainder check fixes the low estimate
  assign rem  = QS_W'(now_r) - qs_r;
  assign slot = (rem >= QS_W'(SLOT_SECONDS)) ? q0_r + NOW_W'(1) : q0_r;

  assign in_stall = (state_r != F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_item   = '{now_seconds: now_r, now_slot: slot, byte_count: bytes_r,
                      restart: restart_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_FIX;
      F_FIX:  state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath: capture, multiply by reciprocal, back-multiply
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      now_r     <= in_now_seconds;
      bytes_r   <= in_byte_count;
      restart_r <= in_restart;
    end
    if (state_r == F_MUL) begin
      prod_r <= 64'(now_r) * 64'(RECIP);
    end
    if (state_r == F_FIX) begin
      q0_r <= prod_r[63:32];
      qs_r <= QS_W'(prod_r[63:32]) * QS_W'(SLOT_SECONDS);
    end
  end

endmodule

### rtl/core/wbrm_fifo.sv
// Two-word queue between the front end and the ring engine.
module wbrm_fifo import wbrm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  wbrm_item_t push_item,
  output logic       full,
  input  logic       pop,
  output wbrm_item_t pop_item,
  output logic       empty
);

  wbrm_item_t  mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

### rtl/core/wbrm_div.sv
// Restoring divider, one quotient bit per cycle.
module wbrm_div import wbrm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;   // dividend bits shift out, quotient bits in
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= CNT_W'(DVD_W - 1);
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
    end
  end

endmodule

### rtl/core/wbrm_back.sv
// Ring engine: slot ring update, totals, rate division and result register.
module wbrm_back import wbrm_pkg::*; #(
  parameter int SLOT_COUNT   = 32,
  parameter int SLOT_SECONDS = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wbrm_item_t          q_item,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TOTAL_W-1:0]  out_rate_kib_q8,
  output logic [TOTAL_W-1:0]  out_window_bytes,
  output logic [GRAND_W-1:0]  out_all_bytes
);

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SS_W   = $clog2(SLOT_SECONDS + 1);
  localparam int PROD_W = NOW_W + SS_W;

  back_state_t            state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [TOTAL_W-1:0]     wtot_r, wtot_nxt;
  logic [NOW_W-1:0]       wstart_r, wstart_nxt;
  logic [GRAND_W-1:0]     grand_r, grand_nxt;
  logic [NOW_W-1:0]       rslot_r, rslot_nxt;     // stamp of never-written entries
  logic [SLOT_COUNT-1:0]  valid_r, valid_nxt;
  logic [NOW_W-1:0]       now_r, now_nxt;
  logic [NOW_W-1:0]       nslot_r, nslot_nxt;
  logic [BYTES_W-1:0]     bytes_r, bytes_nxt;
  logic [TOTAL_W-1:0]     ebytes_r, ebytes_nxt;
  logic [NOW_W-1:0]       estamp_r, estamp_nxt;
  logic [PROD_W-1:0]      sss_r, sss_nxt;
  logic [TOTAL_W-1:0]     rate_r, rate_nxt;
  logic                   oval_r, oval_nxt;
  logic [TOTAL_W-1:0]     orate_r, owin_r;
  logic [GRAND_W-1:0]     oall_r;
  logic                   oload;

  // slot ring storage
  logic [TOTAL_W-1:0]     bytes_mem [SLOT_COUNT];
  logic [NOW_W-1:0]       stamp_mem [SLOT_COUNT];
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [TOTAL_W-1:0]     rd_bytes_q;
  logic [NOW_W-1:0]       rd_stamp_q;
  logic                   wr_en;
  logic [TOTAL_W-1:0]     wr_bytes;

  logic [TOTAL_W-1:0]     eff_bytes;
  logic [NOW_W-1:0]       eff_stamp;
  logic [IDX_W-1:0]       idx_inc;
  logic [NOW_W-1:0]       start_v;
  logic [PROD_W-1:0]      diff;
  div_req_t               dreq;
  div_rsp_t               drsp;

  wbrm_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (dreq),
    .rsp (drsp)
  );

  // entry read back at idx_r; unwritten entries since restart read as empty
  assign eff_bytes = valid_r[idx_r] ? rd_bytes_q : '0;
  assign eff_stamp = valid_r[idx_r] ? rd_stamp_q : rslot_r;
  assign idx_inc   = (idx_r == IDX_W'(SLOT_COUNT - 1)) ? '0 : idx_r + IDX_W'(1);
  assign start_v   = (wtot_r == '0) ? nslot_r : wstart_r;
  assign diff      = PROD_W'(now_r) - sss_r;
  assign wr_bytes  = ebytes_r + TOTAL_W'(bytes_r);

  assign out_valid        = oval_r;
  assign out_rate_kib_q8  = orate_r;
  assign out_window_bytes = owin_r;
  assign out_all_bytes    = oall_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    wtot_nxt   = wtot_r;
    wstart_nxt = wstart_r;
    grand_nxt  = grand_r;
    rslot_nxt  = rslot_r;
    valid_nxt  = valid_r;
    now_nxt    = now_r;
    nslot_nxt  = nslot_r;
    bytes_nxt  = bytes_r;
    ebytes_nxt = ebytes_r;
    estamp_nxt = estamp_r;
    sss_nxt    = sss_r;
    rate_nxt   = rate_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    wr_en      = 1'b0;
    oload      = 1'b0;
    dreq       = '{start: 1'b0, dividend: wtot_r[TOTAL_W-1:2], divisor: diff[DVS_W-1:0]};

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          now_nxt   = q_item.now_seconds;
          nslot_nxt = q_item.now_slot;
          bytes_nxt = q_item.byte_count;
          rd_en     = 1'b1;
          if (q_item.restart) begin
            valid_nxt  = '0;
            idx_nxt    = '0;
            wtot_nxt   = '0;
            wstart_nxt = q_item.now_slot;
            rslot_nxt  = q_item.now_slot;
            rd_addr    = '0;
          end
          state_nxt = B_CUR;
        end
      end
      B_CUR: begin
        if (nslot_r > eff_stamp) begin
          idx_nxt   = idx_inc;
          rd_addr   = idx_inc;
          rd_en     = 1'b1;
          state_nxt = B_NEXT;
        end else begin
          ebytes_nxt = eff_bytes;
          estamp_nxt = eff_stamp;
          state_nxt  = B_ADD;
        end
      end
      B_NEXT: begin
        // retire the oldest entry and reopen it for this slot
        wtot_nxt   = wtot_r - eff_bytes;
        wstart_nxt = eff_stamp;
        ebytes_nxt = '0;
        estamp_nxt = nslot_r;
        state_nxt  = B_ADD;
      end
      B_ADD: begin
        wstart_nxt       = start_v;
        sss_nxt          = PROD_W'(start_v) * PROD_W'(SLOT_SECONDS);
        wr_en            = 1'b1;
        valid_nxt[idx_r] = 1'b1;
        wtot_nxt         = wtot_r + TOTAL_W'(bytes_r);
        grand_nxt        = grand_r + GRAND_W'(bytes_r);
        state_nxt        = B_DIFF;
      end
      B_DIFF: begin
        // rate is zero unless time has moved past the window start
        if (PROD_W'(now_r) > sss_r) begin
          dreq.start = 1'b1;
          state_nxt  = B_DIV;
        end else begin
          rate_nxt  = '0;
          state_nxt = B_PUT;
        end
      end
      B_DIV: begin
        if (drsp.done) begin
          rate_nxt  = TOTAL_W'(drsp.quotient);
          state_nxt = B_PUT;
        end
      end
      B_PUT: begin
        if (!oval_r || !out_stall) begin
          oload     = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    oval_nxt = oval_r;
    if (oload) oval_nxt = 1'b1;
    else if (oval_r && !out_stall) oval_nxt = 1'b0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      idx_r    <= '0;
      wtot_r   <= '0;
      wstart_r <= '0;
      grand_r  <= '0;
      rslot_r  <= '0;
      valid_r  <= '0;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      wtot_r   <= wtot_nxt;
      wstart_r <= wstart_nxt;
      grand_r  <= grand_nxt;
      rslot_r  <= rslot_nxt;
      valid_r  <= valid_nxt;
      oval_r   <= oval_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    now_r    <= now_nxt;
    nslot_r  <= nslot_nxt;
    bytes_r  <= bytes_nxt;
    ebytes_r <= ebytes_nxt;
    estamp_r <= estamp_nxt;
    sss_r    <= sss_nxt;
    rate_r   <= rate_nxt;
    if (oload) begin
      orate_r <= rate_r;
      owin_r  <= wtot_r;
      oall_r  <= grand_r;
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bytes_mem[idx_r] <= wr_bytes;
      stamp_mem[idx_r] <= estamp_r;
    end
    if (rd_en) begin
      rd_bytes_q <= bytes_mem[rd_addr];
      rd_stamp_q <= stamp_mem[rd_addr];
    end
  end

endmodule

### rtl/core/windowed_byte_rate_meter.sv
// Windowed byte rate meter: readings in, window rate and byte totals out.
//
// Input channel (in_*): one word per reading carries the time in seconds,
// the bytes seen since the last reading and a restart flag that empties the
// slot ring before the reading is applied. Output channel (out_*): exactly
// one word per reading with the window rate in KiB/s (8 fraction bits), the
// window byte total and the running byte total since reset.
// Both channels move a word when valid is high and stall is low.
//
// The front end holds in_stall after taking a word while it turns the time into a
// slot number, then parks it in a two-word queue. The ring engine takes one
// reading at a time: ring memory access, the bit-serial rate divider and a load
// of the result register; a zero rate skips the divider.
// A held result does not block the engine from starting the next reading.
//
// Reset empties the ring, the totals and the queue at once; no clearing pass.
// While out_stall is high the result register holds, the engine waits to
// deliver, the queue fills and in_stall then rises.
module windowed_byte_rate_meter import wbrm_pkg::*; #(
  parameter int SLOT_COUNT   = 32,
  parameter int SLOT_SECONDS = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [NOW_W-1:0]    in_now_seconds,
  input  logic [BYTES_W-1:0]  in_byte_count,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TOTAL_W-1:0]  out_rate_kib_q8,
  output logic [TOTAL_W-1:0]  out_window_bytes,
  output logic [GRAND_W-1:0]  out_all_bytes
);

  wbrm_item_t push_item;
  wbrm_item_t pop_item;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;

  wbrm_front #(
    .SLOT_SECONDS (SLOT_SECONDS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_now_seconds (in_now_seconds),
    .in_byte_count  (in_byte_count),
    .in_restart     (in_restart),
    .q_push         (push),
    .q_item         (push_item),
    .q_full         (full)
  );

  wbrm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  wbrm_back #(
    .SLOT_COUNT   (SLOT_COUNT),
    .SLOT_SECONDS (SLOT_SECONDS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_item           (pop_item),
    .q_empty          (empty),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rate_kib_q8  (out_rate_kib_q8),
    .out_window_bytes (out_window_bytes),
    .out_all_bytes    (out_all_bytes)
  );

endmodule

### verif/windowed_byte_rate_meter_test.sv
// Self-checking testbench for the windowed byte rate meter: directed and random readings.
module windowed_byte_rate_meter_test import wbrm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SLOTS  = 32;
  localparam int SLOT_SEC    = 1;
  localparam int STUCK_LIMIT = 10000;
  localparam int SETTLE_CYC  = 200;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  typedef struct packed {
    logic [TOTAL_W-1:0] rate;
    logic [TOTAL_W-1:0] window;
    logic [GRAND_W-1:0] all;
  } meter_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [NOW_W-1:0]    in_now_seconds;
  logic [BYTES_W-1:0]  in_byte_count;
  logic                in_restart;
  logic                out_valid;
  logic                out_stall;
  logic [TOTAL_W-1:0]  out_rate_kib_q8;
  logic [TOTAL_W-1:0]  out_window_bytes;
  logic [GRAND_W-1:0]  out_all_bytes;

  // Shadow copy of the slot ring and totals
  logic [TOTAL_W-1:0]  ring_bytes [RING_SLOTS];
  logic [NOW_W-1:0]    ring_stamp [RING_SLOTS];
  int                  ring_pos;
  logic [TOTAL_W-1:0]  win_total;
  logic [NOW_W-1:0]    win_start;
  logic [GRAND_W-1:0]  total_bytes;

  meter_result_t       pending_results[$];
  meter_result_t       oldest;
  int                  fail_count;
  int                  send_gap_pct;
  int                  stall_pct;
  int                  stuck_cycles;
  logic [NOW_W-1:0]    wall_clock;

  windowed_byte_rate_meter #(
    .SLOT_COUNT  (RING_SLOTS),
    .SLOT_SECONDS(SLOT_SEC)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_now_seconds  (in_now_seconds),
    .in_byte_count   (in_byte_count),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rate_kib_q8 (out_rate_kib_q8),
    .out_window_bytes(out_window_bytes),
    .out_all_bytes   (out_all_bytes)
  );

  always #5 clk = ~clk;

  // Apply one reading to the shadow ring and return the expected word
  function automatic meter_result_t apply_reading(logic [NOW_W-1:0] now,
                                                  logic [BYTES_W-1:0] bytes,
                                                  logic restart);
    logic [NOW_W-1:0] now_slot;
    longint           elapsed;
    logic [63:0]      divisor;
    meter_result_t    res;
    int               i;
    now_slot = now / NOW_W'(SLOT_SEC);
    if (ring_pos >= RING_SLOTS) ring_pos = 0;
    if (restart) begin
      for (i = 0; i < RING_SLOTS; i++) begin
        ring_bytes[i] = '0;
        ring_stamp[i] = now_slot;
      end
      ring_pos  = 0;
      win_total = '0;
      win_start = now_slot;
    end
    // time moved past the current slot: reopen the next entry
    if (now_slot > ring_stamp[ring_pos]) begin
      ring_pos = (ring_pos + 1) % RING_SLOTS;
      win_total = win_total - ring_bytes[ring_pos];
      win_start = ring_stamp[ring_pos];
      ring_bytes[ring_pos] = '0;
      ring_stamp[ring_pos] = now_slot;
    end
    if (win_total == '0) win_start = now_slot;
    ring_bytes[ring_pos] = ring_bytes[ring_pos] + bytes;
    win_total   = win_total + bytes;
    total_bytes = total_bytes + bytes;
    // exact elapsed seconds, no wrap; zero or negative gives a zero rate
    elapsed = longint'({32'd0, now}) - longint'({32'd0, win_start}) * SLOT_SEC;
    if (elapsed <= 0) begin
      res.rate = '0;
    end else begin
      divisor  = elapsed;
      divisor  = divisor << 2;
      res.rate = TOTAL_W'({24'd0, win_total} / divisor);
    end
    res.window = win_total;
    res.all    = total_bytes;
    return res;
  endfunction

  // Offer one word, wait for acceptance, queue its expected result
  task automatic send_reading(logic [NOW_W-1:0] now, logic [BYTES_W-1:0] bytes,
                              logic restart);
    int            gap;
    meter_result_t want_res;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_now_seconds <= now;
    in_byte_count  <= bytes;
    in_restart     <= restart;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    want_res        = apply_reading(now, bytes, restart);
    pending_results = {pending_results, want_res};
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Zero time, zero bytes, largest byte counts and the first ring step
  task automatic test_startup_readings();
    send_reading(32'd0, '0, 1'b0);
    send_reading(32'd0, BYTES_MAX, 1'b0);
    send_reading(32'd1, BYTES_MAX, 1'b0);
    send_reading(32'd4, '0, 1'b0);
    send_reading(32'd4, 24'd1, 1'b0);
    stop_sending();
  endtask

  // Readings with time going backwards never advance the ring
  task automatic test_time_going_back();
    send_reading(32'd2, 24'd500, 1'b0);
    send_reading(32'd4, 24'd123, 1'b0);
    send_reading(32'd0, BYTES_MAX, 1'b0);
    stop_sending();
  endtask

  // Restart at ordinary, top-of-range and high-bit times
  task automatic test_window_restart();
    send_reading(32'd100, BYTES_MAX, 1'b1);
    send_reading(32'd100, '0, 1'b0);
    send_reading(32'd101, 24'd7, 1'b0);
    send_reading(32'hFFFF_FFFF, 24'h80_0000, 1'b1);
    send_reading(32'd0, 24'd1, 1'b0);
    send_reading(32'h8000_0000, 24'd55, 1'b1);
    send_reading(32'h8000_0010, BYTES_MAX, 1'b0);
    stop_sending();
  endtask

  // Empty window keeps its start pinned to the current time
  task automatic test_empty_window();
    send_reading(32'd7, '0, 1'b1);
    send_reading(32'd9, '0, 1'b0);
    send_reading(32'd12, 24'd3, 1'b0);
    stop_sending();
  endtask

  // Sender holds off until every pending result is back, then resumes
  task automatic test_pause_until_drained();
    send_reading(32'd20, 24'd1000, 1'b1);
    send_reading(32'd21, 24'd2000, 1'b0);
    stop_sending();
    wait_results_drained();
    send_reading(32'd25, 24'd3000, 1'b0);
    stop_sending();
  endtask

  // Mostly forward-moving time with random bytes; some restarts, rewinds and jumps
  task automatic test_random_traffic(int count, int gap_pct, int stall_v);
    int               n;
    int               pick;
    logic [BYTES_W-1:0] bytes;
    logic             restart;
    send_gap_pct = gap_pct;
    stall_pct    = stall_v;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 88)      wall_clock = wall_clock + $urandom_range(2);
      else if (pick < 94) wall_clock = wall_clock - $urandom_range(3);
      else                wall_clock = $urandom;
      restart = ($urandom_range(99) < 4);
      pick = $urandom_range(99);
      if (pick < 10)      bytes = '0;
      else if (pick < 20) bytes = BYTES_MAX;
      else if (pick < 50) bytes = BYTES_W'($urandom_range(4095));
      else                bytes = BYTES_W'($urandom);
      send_reading(wall_clock, bytes, restart);
      if ($urandom_range(199) == 0) begin
        stop_sending();
        wait_results_drained();
      end
    end
    stop_sending();
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare each delivered word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual rate %h window %h all %h",
                 $time, out_rate_kib_q8, out_window_bytes, out_all_bytes);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("rate_kib_q8", 64'(oldest.rate), 64'(out_rate_kib_q8));
        check_field("window_bytes", 64'(oldest.window), 64'(out_window_bytes));
        check_field("all_bytes", 64'(oldest.all), 64'(out_all_bytes));
      end
    end
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("windowed_byte_rate_meter_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < RING_SLOTS; i++) begin
      ring_bytes[i] = '0;
      ring_stamp[i] = '0;
    end
    ring_pos       = 0;
    win_total      = '0;
    win_start      = '0;
    total_bytes    = '0;
    fail_count     = 0;
    stuck_cycles   = 0;
    send_gap_pct   = 22;
    stall_pct      = 50;
    wall_clock     = 32'd1000;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_now_seconds <= '0;
    in_byte_count  <= '0;
    in_restart     <= 1'b0;
    out_stall      <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_startup_readings();
    test_time_going_back();
    test_window_restart();
    test_empty_window();
    test_pause_until_drained();
    test_random_traffic(580, 22, 50);
    test_random_traffic(580, 50, 22);
    test_random_traffic(590, 0, 0);

    wait_results_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("windowed_byte_rate_meter_test OK");
    end else begin
      $display("windowed_byte_rate_meter_test NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/wbrm_pkg.sv
rtl/core/wbrm_front.sv
rtl/core/wbrm_fifo.sv
rtl/core/wbrm_div.sv
rtl/core/wbrm_back.sv
rtl/core/windowed_byte_rate_meter.sv
verif/windowed_byte_rate_meter_test.sv
